FILE: rtl/esm_pkg.sv
// Shared constants, types and the quarter-wave cosine table of the envelope-scaled modulator.
`default_nettype none

package esm_pkg;

	// Phase word width and quarter-wave table size.
	localparam int PHASE_BITS  = 16;
	localparam int COS_ENTRIES = 1024;
	localparam int QUAD_BITS   = PHASE_BITS - 2;
	localparam int IDX_W       = $clog2(COS_ENTRIES + 1);

	localparam logic [15:0] Q15_ONE = 16'h8000;

	// Register reset values.
	localparam logic [1:0]  MODE_RESET  = 2'd0;
	localparam logic [15:0] GAIN_RESET  = 16'd16384;
	localparam logic [15:0] FLOOR_RESET = 16'd3277;
	localparam logic [15:0] MIX_RESET   = 16'd16384;

	// Mode code that selects the half-turn pulse instead of the raised cosine.
	localparam logic [1:0] MODE_ISO = 2'd2;

	typedef enum logic [1:0] {
		REG_MODE  = 2'd0,
		REG_GAIN  = 2'd1,
		REG_FLOOR = 2'd2,
		REG_MIX   = 2'd3
	} reg_idx_t;

	typedef logic [15:0] cos_rom_t [COS_ENTRIES + 1];

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// 32768 * cos(x) for x in Q30 over the first quadrant, by an eleven-term series.
	function automatic logic [15:0] cos_q15(input longint unsigned x);
		longint unsigned x2;
		longint unsigned mag;
		longint unsigned v;
		longint sum;
		logic [15:0] res;
		x2 = (x * x) >> 30;
		mag = 64'd1 << 30;
		sum = longint'(mag);
		for (int n = 1; n <= 10; n++) begin
			mag = ((mag * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if ((n % 2) == 1) begin
				sum = sum - longint'(mag);
			end else begin
				sum = sum + longint'(mag);
			end
		end
		if (sum < 0) begin
			res = '0;
		end else begin
			v = (64'(sum) + 64'd16384) >> 15;
			res = (v > 64'd32768) ? Q15_ONE : v[15:0];
		end
		return res;
	endfunction

	function automatic cos_rom_t build_cos_rom();
		cos_rom_t rom;
		for (int k = 0; k <= COS_ENTRIES; k++) begin
			rom[k] = cos_q15((HALF_PI_Q30 * 64'(k)) / COS_ENTRIES);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

`default_nettype wire

FILE: rtl/envelope_scaled_modulator.sv
// Top level of the envelope-scaled modulator: register port, pipeline and output buffer.
//
// Usage:
//   Input channel (in_valid / in_ready) carries envelope, percentile_level,
//   phase_turns and phase_shift; output channel (out_valid / out_ready)
//   carries one Q1.15 modulator gain per item. Registers are set through the APB-style
//   port; the user writes them only while no item is in flight (unchecked by the block).
// Pipeline and throughput:
//   One item is accepted per cycle while in_ready is high. An item passes
//   the input stage, the four divider stages (four radix-2 quotient bits
//   each) and the four chained multiplies of the depth and gain path, the
//   last one just before the output register; the registered cosine table
//   read runs beside the divider.
// Reset:
//   arst_n clears all valid bits, those of the output and skid buffers too,
//   and loads the register defaults; no clearing pass is needed.
// Stall:
//   When the receiver holds out_ready low, one more result lands in a skid
//   register; in_ready then drops and the whole pipeline freezes in place,
//   so nothing is lost or repeated.
`default_nettype none

module envelope_scaled_modulator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] envelope,
	input  wire logic [15:0] percentile_level,
	input  wire logic [15:0] phase_turns,
	input  wire logic [15:0] phase_shift,
	// Output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] modulator
);

	localparam int PB  = esm_pkg::PHASE_BITS;
	localparam int QB  = esm_pkg::QUAD_BITS;
	localparam int IW  = esm_pkg::IDX_W;
	localparam int IPW = QB + IW;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic [1:0]  mode_q;
	logic [15:0] gain_q;
	logic [15:0] floor_q;
	logic [15:0] mix_q;
	esm_pkg::reg_idx_t cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = esm_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= esm_pkg::MODE_RESET;
			gain_q  <= esm_pkg::GAIN_RESET;
			floor_q <= esm_pkg::FLOOR_RESET;
			mix_q   <= esm_pkg::MIX_RESET;
		end else if (psel && penable && pwrite) begin
			case (cfg_sel)
				esm_pkg::REG_MODE:  mode_q  <= pwdata[1:0];
				esm_pkg::REG_GAIN:  gain_q  <= pwdata[15:0];
				esm_pkg::REG_FLOOR: floor_q <= pwdata[15:0];
				esm_pkg::REG_MIX:   mix_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			esm_pkg::REG_MODE:  prdata = {30'd0, mode_q};
			esm_pkg::REG_GAIN:  prdata = {16'd0, gain_q};
			esm_pkg::REG_FLOOR: prdata = {16'd0, floor_q};
			esm_pkg::REG_MIX:   prdata = {16'd0, mix_q};
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic en;
	logic skid_valid_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	assign en       = !skid_valid_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Four restoring division steps; returns the quotient bits above the remainder.
	function automatic logic [19:0] div4(input logic [15:0] rem, input logic [15:0] d,
			input logic [3:0] bits);
		logic [16:0] t;
		logic [15:0] r;
		logic [3:0]  q;
		r = rem;
		q = '0;
		for (int i = 3; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, d}) begin
				r = 16'(t - {1'b0, d});
				q[i] = 1'b1;
			end else begin
				r = t[15:0];
			end
		end
		return {q, r};
	endfunction

	// ------------------------------------------------------------------
	// Stage 1: saturation test, divider seed, phase sum
	// ------------------------------------------------------------------
	logic [15:0] pct_s1, rem_s1;
	logic [7:0]  env_lo_s1;
	logic        sat_s1;
	logic [PB-1:0] ph_s1;

	// The ratio overflows 16 bits exactly when envelope / 256 reaches the
	// percentile; a zero percentile falls in the same case.
	always_ff @(posedge clk) begin
		if (en) begin
			pct_s1    <= percentile_level;
			rem_s1    <= {8'd0, envelope[15:8]};
			env_lo_s1 <= envelope[7:0];
			sat_s1    <= ({8'd0, envelope[15:8]} >= percentile_level);
			ph_s1     <= PB'(phase_turns) + PB'(phase_shift);
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 to 5: divider, cosine address, table read, shape
	// ------------------------------------------------------------------
	logic [19:0] dv2, dv3, dv4, dv5;
	logic [15:0] pct_s2, pct_s3, pct_s4, pct_s5;
	logic [15:0] rem_s2, rem_s3, rem_s4;
	logic [3:0]  env_lo_s2;
	logic        sat_s2, sat_s3, sat_s4, sat_s5;
	logic [3:0]  q_s2;
	logic [7:0]  q_s3;
	logic [11:0] q_s4;
	logic [15:0] q_s5;
	logic [PB-1:0] ph_s2, ph_s3;
	logic [IPW-1:0] idx_prod;
	logic [IW-1:0]  idx_c;
	logic [IW-1:0]  addr_s2;
	logic           neg_s2, neg_s3;
	logic [15:0]    cos_s3;
	logic [15:0]    shape_c;
	logic [15:0]    shape_s4, shape_s5, shape_s6, shape_s7, shape_s8;

	assign dv2 = div4(rem_s1, pct_s1, env_lo_s1[7:4]);
	assign dv3 = div4(rem_s2, pct_s2, env_lo_s2);
	assign dv4 = div4(rem_s3, pct_s3, 4'd0);
	assign dv5 = div4(rem_s4, pct_s4, 4'd0);

	assign idx_prod = IPW'(ph_s1[QB-1:0]) * IPW'(esm_pkg::COS_ENTRIES);
	assign idx_c    = idx_prod[IPW-1:QB];

	always_comb begin
		if (mode_q == esm_pkg::MODE_ISO) begin
			shape_c = ph_s3[PB-1] ? 16'd0 : esm_pkg::Q15_ONE;
		end else if (neg_s3) begin
			shape_c = 16'((17'(esm_pkg::Q15_ONE) - 17'(cos_s3)) >> 1);
		end else begin
			shape_c = 16'((17'(esm_pkg::Q15_ONE) + 17'(cos_s3)) >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pct_s2    <= pct_s1;
			rem_s2    <= dv2[15:0];
			q_s2      <= dv2[19:16];
			env_lo_s2 <= env_lo_s1[3:0];
			sat_s2    <= sat_s1;
			ph_s2     <= ph_s1;
			// Quadrants 1 and 3 read the table mirrored, quadrants 1 and 2 negate.
			addr_s2   <= ph_s1[PB-2] ? IW'(esm_pkg::COS_ENTRIES) - idx_c : idx_c;
			neg_s2    <= ph_s1[PB-1] ^ ph_s1[PB-2];

			pct_s3 <= pct_s2;
			rem_s3 <= dv3[15:0];
			q_s3   <= {q_s2, dv3[19:16]};
			sat_s3 <= sat_s2;
			ph_s3  <= ph_s2;
			neg_s3 <= neg_s2;
			cos_s3 <= esm_pkg::COS_ROM[addr_s2];

			pct_s4   <= pct_s3;
			rem_s4   <= dv4[15:0];
			q_s4     <= {q_s3, dv4[19:16]};
			sat_s4   <= sat_s3;
			shape_s4 <= shape_c;

			pct_s5   <= pct_s4;
			q_s5     <= {q_s4, dv5[19:16]};
			sat_s5   <= sat_s4;
			shape_s5 <= shape_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stages 6 to 8: inner factor, depth, floor product
	// ------------------------------------------------------------------
	logic [15:0]        ratio_c;
	logic signed [17:0] ratio_m;
	logic signed [16:0] mix_m;
	logic signed [34:0] inner_c, inner_s6;
	logic               inner_pos;
	logic [47:0]        prod_s7;
	logic [24:0]        depth_hi;
	logic [15:0]        depth_c, flr_c, diff_c;
	logic [15:0]        flr_s8;
	logic [30:0]        prod2_s8;

	assign ratio_c   = sat_s5 ? 16'hFFFF : q_s5;
	assign ratio_m   = $signed({2'b00, ratio_c}) - 18'sd256;
	assign mix_m     = $signed({1'b0, mix_q});
	assign inner_c   = 35'(ratio_m * mix_m) + 35'sd8388608;
	assign inner_pos = !inner_s6[34] && (inner_s6 != '0);

	assign depth_hi = prod_s7[47:23];
	assign depth_c  = (depth_hi > 25'(esm_pkg::Q15_ONE)) ? esm_pkg::Q15_ONE : depth_hi[15:0];
	assign flr_c    = (floor_q > esm_pkg::Q15_ONE) ? esm_pkg::Q15_ONE : floor_q;
	assign diff_c   = esm_pkg::Q15_ONE - flr_c;

	always_ff @(posedge clk) begin
		if (en) begin
			inner_s6 <= inner_c;
			shape_s6 <= shape_s5;

			prod_s7  <= inner_pos ? 48'(inner_s6[31:0]) * 48'(gain_q) : '0;
			shape_s7 <= shape_s6;

			prod2_s8 <= 31'(32'(diff_c) * 32'(depth_c));
			flr_s8   <= flr_c;
			shape_s8 <= shape_s7;
		end
	end

	// ------------------------------------------------------------------
	// Output register with skid buffer
	// ------------------------------------------------------------------
	logic [46:0] fin_prod;
	logic [15:0] res_c;
	logic        out_valid_q;
	logic [15:0] mod_q, skid_q;

	assign fin_prod = 47'(prod2_s8) * 47'(shape_s8);
	assign res_c    = flr_s8 + fin_prod[45:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= v_s8;
			end
		end else if (v_s8) begin
			// Receiver stalled with a result waiting: park the new item.
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			mod_q <= skid_valid_q ? skid_q : res_c;
		end else if (en && v_s8) begin
			skid_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign modulator = mod_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid buffer holds an item while the output register is empty");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (mod_q <= esm_pkg::Q15_ONE))
		else $error("modulator gain above one");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input blocked without a stalled output");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> ($stable(v_s8) && $stable(prod2_s8)))
		else $error("pipeline moved while frozen");

endmodule

`default_nettype wire
